FILE: src/sorted_table_insert_search_unit_defines.svh
// Assertion helpers shared by the sorted table unit.
`ifndef SORTED_TABLE_INSERT_SEARCH_UNIT_DEFINES_SVH
`define SORTED_TABLE_INSERT_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STSU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stsu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define STSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stsu assertion failed");

`endif

FILE: src/stsu_pkg.sv
// ----------------------------------------------------------------------------
// stsu_pkg
// Types and codes for the sorted table insert/search unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stsu_pkg;

    localparam int POS_W   = 9;
    localparam int COUNT_W = 10;
    localparam int KEY_W   = 32;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_SEARCH = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [KEY_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
        logic               full_drop;
        logic [COUNT_W-1:0] entries_now;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_SHIFT,
        S_DRAIN,
        S_PLACE,
        S_DONE
    } t_state;

endpackage

FILE: src/stsu_ram.sv
// ----------------------------------------------------------------------------
// stsu_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/sorted_table_insert_search_unit.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_search_unit
// Ascending table of signed keys with insert, binary search and clear.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the keys live in a single RAM with one
// read and one write port. Each binary probe is a read (S_PROBE), then a
// compare (S_CMP). A search stops on the probe that hits, or misses after
// at most ceil(log2(count+1)) probes. An insert finds its place by the same
// probing (upper bound), then moves the larger keys up one entry per cycle;
// an insert at the end of the table needs no moves. Clear, unused action
// codes and full-table inserts go straight to the result without probing.
// The next item is taken while a finished result still waits in the output
// register; a new result that finds that register still occupied holds the
// unit until the output register is taken.
`timescale 1ns / 1ps

`include "sorted_table_insert_search_unit_defines.svh"

module sorted_table_insert_search_unit #(
    parameter int TABLE_DEPTH = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  stsu_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output stsu_pkg::t_out_item o_out_item
);

    import stsu_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic                    r_out_valid, n_out_valid;
    logic                    r_sh_wen, n_sh_wen;

    logic [1:0]              r_op, n_op;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [CW-1:0]           r_lo, n_lo;
    logic [CW-1:0]           r_hi, n_hi;       // exclusive upper bound
    logic [AW-1:0]           r_mid, n_mid;
    logic [AW-1:0]           r_idx, n_idx;
    logic [AW-1:0]           r_sh_waddr, n_sh_waddr;
    logic                    r_found, n_found;
    logic [AW-1:0]           r_pos, n_pos;
    logic                    r_drop, n_drop;
    t_out_item               r_out_item, n_out_item;

    logic                    ram_wr_en;
    logic [AW-1:0]           ram_wr_addr;
    logic [KEY_W-1:0]        ram_wr_data;
    logic                    ram_rd_en;
    logic [AW-1:0]           ram_rd_addr;
    logic [KEY_W-1:0]        ram_rd_data;

    logic [CW:0]             mid_sum;
    logic [AW-1:0]           mid_calc;
    logic signed [KEY_W-1:0] entry;
    logic                    go_right;
    logic [31:0]             pos_ext;
    logic [31:0]             count_ext;

    stsu_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // floor((lo + hi_incl) / 2) with hi_incl = hi - 1; only used while lo < hi
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi} - (CW + 1)'(1);
    assign mid_calc = mid_sum[AW:1];
    assign entry    = $signed(ram_rd_data);
    // insert looks for the upper bound, so equal keys go right as well
    assign go_right = (r_op == ACT_INSERT) ? (entry <= r_key) : (entry < r_key);

    assign pos_ext   = 32'(r_pos);
    assign count_ext = 32'(r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_sh_wen    = 1'b0;
        n_op        = r_op;
        n_key       = r_key;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_idx       = r_idx;
        n_sh_waddr  = r_sh_waddr;
        n_found     = r_found;
        n_pos       = r_pos;
        n_drop      = r_drop;
        n_out_item  = r_out_item;

        ram_rd_en   = 1'b0;
        ram_rd_addr = r_mid;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_sh_waddr;
        ram_wr_data = ram_rd_data;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // pending move of one key up by one entry
        if (r_sh_wen) begin
            ram_wr_en = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in_item.action;
                    n_key   = i_in_item.value;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_found = 1'b0;
                    n_pos   = '0;
                    n_drop  = 1'b0;
                    priority if (i_in_item.action == ACT_INSERT) begin
                        if (r_count >= CW'(TABLE_DEPTH)) begin
                            n_drop  = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_PROBE;
                        end
                    end else if (i_in_item.action == ACT_SEARCH) begin
                        n_state = S_PROBE;
                    end else if (i_in_item.action == ACT_CLEAR) begin
                        n_count = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_PROBE: begin
                if (r_lo < r_hi) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = mid_calc;
                    n_mid       = mid_calc;
                    n_state     = S_CMP;
                end else if (r_op == ACT_SEARCH) begin
                    n_state = S_DONE;
                end else if (r_count > r_lo) begin
                    n_idx   = AW'(r_count - CW'(1));
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_CMP: begin
                if (r_op == ACT_SEARCH && entry == r_key) begin
                    n_found = 1'b1;
                    n_pos   = r_mid;
                    n_state = S_DONE;
                end else begin
                    if (go_right) begin
                        n_lo = CW'(r_mid) + CW'(1);
                    end else begin
                        n_hi = CW'(r_mid);
                    end
                    n_state = S_PROBE;
                end
            end
            S_SHIFT: begin
                // read entry idx now, write it to idx + 1 next cycle
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_idx;
                n_sh_wen    = 1'b1;
                n_sh_waddr  = r_idx + AW'(1);
                if (r_idx == AW'(r_lo)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx - AW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_PLACE;
            end
            S_PLACE: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = AW'(r_lo);
                ram_wr_data = r_key;
                n_pos       = AW'(r_lo);
                n_count     = r_count + CW'(1);
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid            = 1'b1;
                    n_out_item.found       = r_found;
                    n_out_item.position    = pos_ext[POS_W-1:0];
                    n_out_item.full_drop   = r_drop;
                    n_out_item.entries_now = count_ext[COUNT_W-1:0];
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_sh_wen    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_sh_wen    <= n_sh_wen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_idx      <= n_idx;
        r_sh_waddr <= n_sh_waddr;
        r_found    <= n_found;
        r_pos      <= n_pos;
        r_drop     <= n_drop;
        r_out_item <= n_out_item;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `STSU_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_DEPTH))
    `STSU_ASSERT_IMPL(a_cmp_window, i_clk, i_rst_n, r_state == S_CMP, r_lo < r_hi)
    `STSU_ASSERT_IMPL(a_move_in_table, i_clk, i_rst_n, r_sh_wen, CW'(r_sh_waddr) <= r_count)
    `STSU_ASSERT_IMPL(a_place_room, i_clk, i_rst_n, r_state == S_PLACE, r_count < CW'(TABLE_DEPTH))
    `STSU_ASSERT_IMPL(a_found_search, i_clk, i_rst_n, r_state == S_DONE && r_found,
                      r_op == ACT_SEARCH)
    `STSU_ASSERT_NEXT(a_place_counts, i_clk, i_rst_n, r_state == S_PLACE,
                      r_count == $past(r_count) + CW'(1))

endmodule
